// ===== rtl/core/bcf_pkg.sv =====
// bcf_pkg: shared constants, types and helper functions for the biquad cascade.
// Used by bcf_ctrl, bcf_dpath, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps

package bcf_pkg;

   localparam int MAX_BANDS     = 64;
   localparam int NUM_CHANNELS  = 2;
   localparam int SAMPLE_W      = 24;
   localparam int COEFS_PER_BAND = 5;

   localparam int COEF_W   = 32;                  // Q4.28
   localparam int HIST_W   = 48;                  // Q8.40
   localparam int HIST_FRAC = 40;
   localparam int MULQ_SH  = 16;                  // Q8.40 -> Q8.24 operand
   localparam int MULQ_W   = HIST_W - MULQ_SH;
   localparam int PROD_W   = COEF_W + MULQ_W;
   localparam int RND_SH   = 12;                  // Q12.52 -> Q12.40
   localparam int RND_W    = PROD_W - RND_SH;
   localparam int ACC_W    = RND_W + 4;
   localparam int IN_SH    = HIST_FRAC + 1 - SAMPLE_W;
   localparam int OUT_W    = HIST_W + 1 - IN_SH;

   localparam int BAND_W   = $clog2(MAX_BANDS);
   localparam int CNT_W    = $clog2(MAX_BANDS + 1);
   localparam int CHAN_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CFG_W    = 7;
   localparam int SLOT_W   = 3;
   localparam int COEF_DEPTH = MAX_BANDS * COEFS_PER_BAND;
   localparam int COEF_AW  = $clog2(COEF_DEPTH);
   localparam int HIST_ROWS = MAX_BANDS * NUM_CHANNELS;
   localparam int HIST_AW  = $clog2(HIST_ROWS);

   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic [0:0] {
      OP_FILTER     = 1'b0,
      OP_COEF_WRITE = 1'b1
   } op_type;

   typedef enum logic [SLOT_W-1:0] {
      SLOT_B0 = 3'd0,
      SLOT_B1 = 3'd1,
      SLOT_B2 = 3'd2,
      SLOT_A1 = 3'd3,
      SLOT_A2 = 3'd4
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN_S1,
      ST_DRAIN_S2,
      ST_EMIT
   } state_type;

   // phases of one section, overlapping the previous section's tail
   typedef enum logic [2:0] {
      PH_LOAD,
      PH_MUL_B0,
      PH_MUL_B1,
      PH_MUL_B2,
      PH_MUL_A1
   } phase_type;

   typedef struct packed {
      logic               load_sample;
      logic               coef_wr;
      logic               coef_rd;
      logic [COEF_AW-1:0] coef_addr;
      logic               hist_rd;
      logic [BAND_W-1:0]  hist_rd_band;
      logic               hist_wr;
      logic [BAND_W-1:0]  hist_wr_band;
      logic               mul_en;
      logic               mul_use_o;
      logic               v_load;
      logic               v_first;
      logic               o_en;
      logic               acc1_en;
      logic               acc2_en;
      logic               s1_en;
      logic               out_load;
   } bcf_cmd_type;

   function automatic logic [COEF_AW-1:0] coef_addr(input logic [BAND_W-1:0] band,
                                                    input logic [SLOT_W-1:0] slot);
      coef_addr = COEF_AW'(band) * COEF_AW'(COEFS_PER_BAND) + COEF_AW'(slot);
   endfunction

   function automatic logic signed [HIST_W-1:0] sat_hist(input logic signed [ACC_W-1:0] x);
      logic [ACC_W-HIST_W:0] top;
      top = x[ACC_W-1:HIST_W-1];
      if (&top || ~|top)
         sat_hist = x[HIST_W-1:0];
      else if (x[ACC_W-1])
         sat_hist = {1'b1, {(HIST_W-1){1'b0}}};
      else
         sat_hist = {1'b0, {(HIST_W-1){1'b1}}};
   endfunction

   function automatic logic signed [ACC_W-1:0] ext_hist(input logic signed [HIST_W-1:0] x);
      ext_hist = {{(ACC_W-HIST_W){x[HIST_W-1]}}, x};
   endfunction

   function automatic logic signed [ACC_W-1:0] ext_rnd(input logic signed [RND_W-1:0] x);
      ext_rnd = {{(ACC_W-RND_W){x[RND_W-1]}}, x};
   endfunction

endpackage

// ===== rtl/core/biquad_cascade_filter_unit.sv =====
// biquad_cascade_filter_unit: top level of the two-channel cascaded biquad
// (transposed direct form II). Depends on bcf_pkg, bcf_ctrl and bcf_dpath.
//
//   channel  dir  beat moves
//   req_*    in   filter sample or coefficient word (tuser[0] selects)
//   rsp_*    out  filtered, clipped sample, one per filter beat
//   csr_*    in   band count write
//
// A filter beat holds ready low from acceptance until its result is loaded
// into the result register, while the single shared 32x32 multiplier forms
// five products per section for each of the N sections in use. A coefficient
// beat is written on acceptance and leaves ready high.
// Reset clears the history valid bits and sets the band count to one in the
// same cycle; there is no clearing pass.
// The result register holds a stalled beat while the next one is accepted;
// a finished result waits inside the block until that register is free.
`timescale 1ns / 1ps

module biquad_cascade_filter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bcf_pkg::CFG_W-1:0]           csr_wdata,    // band_count
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sample_in[23:0], band_select[29:24], coeff_slot[32:30], coeff_value[64:33]
   input  logic [bcf_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [bcf_pkg::REQ_TUSER_W-1:0]     req_tuser,    // operation, channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bcf_pkg::RSP_TDATA_W-1:0]     rsp_tdata,    // sample_out
   output logic [bcf_pkg::RSP_TUSER_W-1:0]     rsp_tuser     // channel_out, clipped
);
   import bcf_pkg::*;

   localparam int BAND_LSB  = SAMPLE_W;
   localparam int SLOT_LSB  = BAND_LSB + BAND_W;
   localparam int COEF_LSB  = SLOT_LSB + SLOT_W;

   bcf_cmd_type               cmd;
   logic                      out_blocked;
   logic                      operation;
   logic [CHAN_W-1:0]         channel;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic [BAND_W-1:0]         band_select;
   logic [SLOT_W-1:0]         coeff_slot;
   logic signed [COEF_W-1:0]  coeff_value;

   assign operation   = req_tuser[0];
   assign channel     = req_tuser[1 +: CHAN_W];
   assign sample_in   = req_tdata[SAMPLE_W-1:0];
   assign band_select = req_tdata[BAND_LSB +: BAND_W];
   assign coeff_slot  = req_tdata[SLOT_LSB +: SLOT_W];
   assign coeff_value = req_tdata[COEF_LSB +: COEF_W];

   bcf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .operation   (operation),
      .band_select (band_select),
      .coeff_slot  (coeff_slot),
      .out_blocked (out_blocked),
      .cmd         (cmd)
   );

   bcf_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .channel     (channel),
      .sample_in   (sample_in),
      .coeff_value (coeff_value),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .out_blocked (out_blocked)
   );

endmodule

// ===== rtl/core/bcf_ctrl.sv =====
// bcf_ctrl: sequencer for the biquad cascade; band count register, section and
// phase counters, and the command word for bcf_dpath.
// Depends on bcf_pkg.
`timescale 1ns / 1ps

module bcf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bcf_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          operation,
   input  logic [bcf_pkg::BAND_W-1:0]    band_select,
   input  logic [bcf_pkg::SLOT_W-1:0]    coeff_slot,
   input  logic                          out_blocked,
   output bcf_pkg::bcf_cmd_type          cmd
);
   import bcf_pkg::*;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   band_ff, band_in;
   logic [CFG_W-1:0]   band_count_ff;
   logic [CNT_W-1:0]   bands_used;
   logic [CNT_W-1:0]   band_m1;
   logic [CNT_W-1:0]   band_p1;
   logic               accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_LOAD;
         band_ff       <= '0;
         band_count_ff <= CFG_W'(1);
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         band_ff  <= band_in;
         if (csr_we) begin
            band_count_ff <= csr_wdata;
         end
      end
   end

   // zero acts as one section, anything above the store depth as the depth
   always_comb begin
      priority if (band_count_ff == '0)
         bands_used = CNT_W'(1);
      else if (CNT_W'(band_count_ff) > CNT_W'(MAX_BANDS))
         bands_used = CNT_W'(MAX_BANDS);
      else
         bands_used = CNT_W'(band_count_ff);
   end

   assign band_m1    = band_ff - CNT_W'(1);
   assign band_p1    = band_ff + CNT_W'(1);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      band_in  = band_ff;
      cmd      = '0;
      cmd.hist_rd_band = band_ff[BAND_W-1:0];
      cmd.hist_wr_band = band_m1[BAND_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            cmd.coef_addr = coef_addr(band_select, coeff_slot);
            if (accept) begin
               if (operation == OP_COEF_WRITE) begin
                  cmd.coef_wr = (coeff_slot < SLOT_W'(COEFS_PER_BAND));
               end else begin
                  cmd.load_sample = 1'b1;
                  band_in  = '0;
                  phase_in = PH_LOAD;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            cmd.coef_rd = 1'b1;
            cmd.mul_en  = 1'b1;
            unique case (phase_ff)
               PH_LOAD: begin
                  // a2 product and s1 of the previous section overlap this read
                  cmd.coef_addr = coef_addr(band_ff[BAND_W-1:0], SLOT_B0);
                  cmd.hist_rd   = 1'b1;
                  cmd.v_load    = 1'b1;
                  cmd.v_first   = (band_ff == '0);
                  cmd.mul_use_o = 1'b1;
                  cmd.s1_en     = (band_ff != '0);
                  phase_in      = PH_MUL_B0;
               end
               PH_MUL_B0: begin
                  cmd.coef_addr = coef_addr(band_ff[BAND_W-1:0], SLOT_B1);
                  cmd.hist_wr   = (band_ff != '0);
                  phase_in      = PH_MUL_B1;
               end
               PH_MUL_B1: begin
                  cmd.coef_addr = coef_addr(band_ff[BAND_W-1:0], SLOT_B2);
                  cmd.o_en      = 1'b1;
                  phase_in      = PH_MUL_B2;
               end
               PH_MUL_B2: begin
                  cmd.coef_addr = coef_addr(band_ff[BAND_W-1:0], SLOT_A1);
                  cmd.acc1_en   = 1'b1;
                  phase_in      = PH_MUL_A1;
               end
               PH_MUL_A1: begin
                  cmd.coef_addr = coef_addr(band_ff[BAND_W-1:0], SLOT_A2);
                  cmd.mul_use_o = 1'b1;
                  cmd.acc2_en   = 1'b1;
                  band_in       = band_p1;
                  phase_in      = PH_LOAD;
                  if (band_p1 == bands_used) begin
                     state_in = ST_DRAIN_S1;
                  end
               end
               default: begin
                  phase_in = PH_LOAD;
               end
            endcase
         end
         ST_DRAIN_S1: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_use_o = 1'b1;
            cmd.s1_en     = 1'b1;
            state_in      = ST_DRAIN_S2;
         end
         ST_DRAIN_S2: begin
            cmd.hist_wr = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_blocked) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/bcf_dpath.sv =====
// bcf_dpath: coefficient store, history store, shared 32x32 multiplier,
// accumulators and the output register of the biquad cascade.
// Depends on bcf_pkg; driven by bcf_ctrl.
`timescale 1ns / 1ps

module bcf_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bcf_pkg::bcf_cmd_type                  cmd,
   input  logic [bcf_pkg::CHAN_W-1:0]            channel,
   input  logic signed [bcf_pkg::SAMPLE_W-1:0]   sample_in,
   input  logic signed [bcf_pkg::COEF_W-1:0]     coeff_value,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [bcf_pkg::RSP_TDATA_W-1:0]       rsp_tdata,  // sample_out
   output logic [bcf_pkg::RSP_TUSER_W-1:0]       rsp_tuser,  // channel_out, clipped
   output logic                                  out_blocked
);
   import bcf_pkg::*;

   logic [COEF_W-1:0]         coef_mem [COEF_DEPTH];
   logic signed [COEF_W-1:0]  coef_rd_ff;
   logic [2*HIST_W-1:0]       hist_mem [HIST_ROWS];
   logic [2*HIST_W-1:0]       hist_rd_ff;
   logic                      hist_rd_valid_ff;
   logic [HIST_ROWS-1:0]      hist_valid_ff;
   logic [HIST_AW-1:0]        hist_rd_row;
   logic [HIST_AW-1:0]        hist_wr_row;
   logic [2*HIST_W-1:0]       hist_wr_data;

   logic [CHAN_W-1:0]         chan_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [HIST_W-1:0]  v_ff, v_in;
   logic signed [HIST_W-1:0]  o_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc1_ff, acc2_ff;
   logic signed [HIST_W-1:0]  s1n_ff;

   logic signed [MULQ_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]  rnd_sum;
   logic signed [RND_W-1:0]   rnd;
   logic signed [HIST_W-1:0]  s1_rd, s2_rd, s2_new;

   logic signed [HIST_W:0]    out_sum;
   logic signed [OUT_W-1:0]   out_r;
   logic [OUT_W-SAMPLE_W:0]   out_top;
   logic [SAMPLE_W-1:0]       out_sample;
   logic                      out_clip;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]         rsp_chan_ff;
   logic [SAMPLE_W-1:0]       rsp_sample_ff;
   logic                      rsp_clip_ff;

   // coefficient store: undefined until written, read data registered
   always_ff @(posedge clock) begin
      if (cmd.coef_wr) begin
         coef_mem[cmd.coef_addr] <= coeff_value;
      end
      if (cmd.coef_rd) begin
         coef_rd_ff <= coef_mem[cmd.coef_addr];
      end
   end

   // history store: one row of {s2, s1} per section and channel
   assign hist_rd_row  = {cmd.hist_rd_band, chan_ff};
   assign hist_wr_row  = {cmd.hist_wr_band, chan_ff};
   assign hist_wr_data = {s2_new, s1n_ff};

   always_ff @(posedge clock) begin
      if (cmd.hist_wr) begin
         hist_mem[hist_wr_row] <= hist_wr_data;
      end
      if (cmd.hist_rd) begin
         hist_rd_ff <= hist_mem[hist_rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff    <= '0;
         hist_rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.hist_wr) begin
            hist_valid_ff[hist_wr_row] <= 1'b1;
         end
         if (cmd.hist_rd) begin
            hist_rd_valid_ff <= hist_valid_ff[hist_rd_row];
         end
      end
   end

   assign s1_rd = hist_rd_valid_ff ? hist_rd_ff[HIST_W-1:0]        : '0;
   assign s2_rd = hist_rd_valid_ff ? hist_rd_ff[2*HIST_W-1:HIST_W] : '0;

   // multiplier operand is the Q8.24 view of the running value
   assign mul_b   = cmd.mul_use_o ? o_ff[HIST_W-1:MULQ_SH] : v_ff[HIST_W-1:MULQ_SH];
   assign rnd_sum = prod_ff + PROD_W'(signed'(1) <<< (RND_SH - 1));
   assign rnd     = rnd_sum[PROD_W-1:RND_SH];
   assign s2_new  = sat_hist(acc2_ff - ext_rnd(rnd));

   assign v_in = cmd.v_first
      ? {{(HIST_W-SAMPLE_W-IN_SH){sample_ff[SAMPLE_W-1]}}, sample_ff, {IN_SH{1'b0}}}
      : o_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         chan_ff   <= channel;
         sample_ff <= sample_in;
      end
      if (cmd.v_load) begin
         v_ff <= v_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= coef_rd_ff * mul_b;
      end
      if (cmd.o_en) begin
         o_ff <= sat_hist(ext_rnd(rnd) + ext_hist(s1_rd));
      end
      if (cmd.acc1_en) begin
         acc1_ff <= ext_rnd(rnd) + ext_hist(s2_rd);
      end
      if (cmd.acc2_en) begin
         acc2_ff <= ext_rnd(rnd);
      end
      if (cmd.s1_en) begin
         s1n_ff <= sat_hist(acc1_ff - ext_rnd(rnd));
      end
   end

   // Q8.40 back to the sample format, round half up, then clip
   assign out_sum = {o_ff[HIST_W-1], o_ff} + (HIST_W+1)'(signed'(1) <<< (IN_SH - 1));
   assign out_r   = out_sum[HIST_W:IN_SH];
   assign out_top = out_r[OUT_W-1:SAMPLE_W-1];

   always_comb begin
      out_clip = !(&out_top || ~|out_top);
      priority if (!out_clip)
         out_sample = out_r[SAMPLE_W-1:0];
      else if (out_r[OUT_W-1])
         out_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
      else
         out_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
   end

   assign out_blocked  = rsp_valid_ff && !rsp_tready;
   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_chan_ff   <= chan_ff;
         rsp_sample_ff <= out_sample;
         rsp_clip_ff   <= out_clip;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_sample_ff);
   assign rsp_tuser  = {rsp_clip_ff, rsp_chan_ff};

endmodule

// ===== rtl/core/bcf_checker.sv =====
// bcf_checker: port-level checks on the biquad cascade top level, and its bind.
// Depends on bcf_pkg and biquad_cascade_filter_unit.
`timescale 1ns / 1ps

module bcf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             csr_we,
   input logic [bcf_pkg::CFG_W-1:0]        csr_wdata,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [bcf_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bcf_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [bcf_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import bcf_pkg::*;

   logic req_beat;
   logic cfg_touch;
   assign req_beat  = req_tvalid && req_tready;
   assign cfg_touch = csr_we && (csr_wdata != '0);

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // clipped samples sit on a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         (rsp_tdata == {1'b0, {(RSP_TDATA_W-1){1'b1}}}) ||
         (rsp_tdata == {1'b1, {(RSP_TDATA_W-1){1'b0}}}))
      else $error("clip flag without saturated sample");

   // result register empty straight after reset
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // a coefficient beat never makes a result
   a_coef_silent: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_tuser[0] == OP_COEF_WRITE) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result after coefficient beat");

   // a filter beat occupies the sequencer, so ready is low in the next cycle
   a_filter_busy: assert property (@(posedge clock) disable iff (reset || cfg_touch)
      req_beat && (req_tuser[0] == OP_FILTER) |=> !req_tready)
      else $error("ready straight after filter beat");

endmodule

bind biquad_cascade_filter_unit bcf_checker u_bcf_checker (
   .clock      (clock),
   .reset      (reset),
   .csr_we     (csr_we),
   .csr_wdata  (csr_wdata),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
